/* rtl/pvrc_pkg.sv */
// Shared types and constants of the panorama view remap coordinate generator.
// Holds the arctangent table, fixed-point constants and configuration indexes.
// No dependencies.
`default_nettype none

package pvrc_pkg;

  // datapath width of every CORDIC cell
  localparam int unsigned CW = 36;
  localparam int unsigned ATAN_TAB_LEN = 24;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [47:0] VX_RAY = 48'd4026531840;
  localparam logic [20:0] OUT_MAX = 21'd2097151;

  typedef enum logic [2:0] {
    CFG_PROJ_WIDTH  = 3'd0,
    CFG_PROJ_HEIGHT = 3'd1,
    CFG_PANO_WIDTH  = 3'd2,
    CFG_PANO_HEIGHT = 3'd3,
    CFG_RAY_STEP_Y  = 3'd4,
    CFG_RAY_STEP_Z  = 3'd5,
    CFG_YAW_ANGLE   = 3'd6,
    CFG_PITCH_ANGLE = 3'd7
  } cfg_idx_e;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [29:0] atan_at(input logic [4:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10680862;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/pvrc_rot_cell.sv */
// One rotation-mode CORDIC step with a registered output.
// Uses pvrc_pkg for the datapath width and the arctangent table.
`default_nettype none

module pvrc_rot_cell import pvrc_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 1
) (
  input  wire logic                 clk_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [CW-1:0] z_i,
  input  wire logic [PW-1:0]        pay_i,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic signed [CW-1:0]      z_o,
  output logic [PW-1:0]             pay_o
);

  localparam logic signed [CW-1:0] ATAN = $signed(CW'(atan_at(5'(IDX))));

  logic signed [CW-1:0] x_d, y_d, z_d, x_q, y_q, z_q;
  logic [PW-1:0]        pay_q;

  always_comb begin
    if (!z_i[CW-1]) begin
      x_d = x_i - (y_i >>> IDX);
      y_d = y_i + (x_i >>> IDX);
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + (y_i >>> IDX);
      y_d = y_i - (x_i >>> IDX);
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    pay_q <= pay_i;
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign pay_o = pay_q;

endmodule

`default_nettype wire

/* rtl/pvrc_vec_cell.sv */
// One vectoring-mode CORDIC step with a registered output and valid bit.
// Uses pvrc_pkg for the datapath width and the arctangent table.
`default_nettype none

module pvrc_vec_cell import pvrc_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [CW-1:0] z_i,
  input  wire logic [PW-1:0]        pay_i,
  output logic                      valid_o,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic signed [CW-1:0]      z_o,
  output logic [PW-1:0]             pay_o
);

  localparam logic signed [CW-1:0] ATAN = $signed(CW'(atan_at(5'(IDX))));

  logic signed [CW-1:0] x_d, y_d, z_d, x_q, y_q, z_q;
  logic [PW-1:0]        pay_q;
  logic                 valid_q;

  always_comb begin
    if (!y_i[CW-1]) begin
      x_d = x_i + (y_i >>> IDX);
      y_d = y_i - (x_i >>> IDX);
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - (y_i >>> IDX);
      y_d = y_i + (x_i >>> IDX);
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    pay_q <= pay_i;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign pay_o   = pay_q;

endmodule

`default_nettype wire

/* rtl/panorama_view_remap_coordinates_core.sv */
// Top level of the panorama view remap coordinate generator.
// Uses pvrc_pkg, pvrc_rot_cell and pvrc_vec_cell.
`default_nettype none

// Maps a perspective view pixel to a source point in an equirectangular panorama.
// Input channel: a pixel word (pixel_row_i, pixel_col_i) is taken at each clock edge
// where start_i is high and busy_o is low. busy_o is high only during reset and the
// cycle after it, so a new pixel may enter every cycle.
// Result channel: done_o is high for one cycle with map_x_o / map_y_o (Q13.8).
// The receiver cannot stall; results leave in input order, one per pixel.
// Each CORDIC chain has min(CORDIC_ITERS, 24) steps.
// Throughput: one pixel per cycle. The pipeline holds rows of CORDIC cells: two
// sine/cosine chains run from the angle registers, and two vectoring chains form
// longitude and latitude; every cell takes one step per clock.
// Configuration: cfg_valid_i / cfg_ready_o carry a register index and data word.
// Write only while no pixel is in flight. Reset loads the default view setup and
// empties the pipeline.
module panorama_view_remap_coordinates_core import pvrc_pkg::*; #(
  parameter int unsigned MAX_VIEW_DIM = 4096,
  parameter int unsigned MAX_PANO_DIM = 8192,
  parameter int unsigned CORDIC_ITERS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [11:0] pixel_row_i,
  input  wire logic [11:0] pixel_col_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic [20:0]      map_x_o,
  output logic [20:0]      map_y_o
);

  localparam int unsigned NITER = (CORDIC_ITERS < ATAN_TAB_LEN) ? CORDIC_ITERS
                                                                 : ATAN_TAB_LEN;
  localparam int unsigned DLY = NITER - 3;
  localparam int unsigned LATENCY = DLY + 13 + 2 * NITER;

  localparam logic signed [CW-1:0] HALF = 36'sd2147483648;
  localparam logic signed [CW-1:0] TURN = 36'sd4294967296;
  localparam logic signed [CW-1:0] QTR  = 36'sd1073741824;

  // ---------------------------------------------------------------- control
  logic busy_q, cfg_ready_q, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      cfg_ready_q <= 1'b0;
    end else begin
      busy_q      <= 1'b0;
      cfg_ready_q <= 1'b1;
    end
  end

  assign busy_o      = busy_q;
  assign cfg_ready_o = cfg_ready_q;
  assign accept      = start_i && !busy_q;

  // ---------------------------------------------------------------- registers
  logic [12:0]        proj_w_q, proj_h_q;
  logic [13:0]        pano_w_q, pano_h_q;
  logic [31:0]        step_y_q, step_z_q;
  logic signed [15:0] yaw_q, pitch_q;
  logic [12:0]        view_sat;
  logic [13:0]        pano_sat;

  always_comb begin
    view_sat = cfg_data_i[12:0];
    if (32'(cfg_data_i[12:0]) > 32'(MAX_VIEW_DIM)) begin
      view_sat = 13'(MAX_VIEW_DIM);
    end
    pano_sat = cfg_data_i[13:0];
    if (32'(cfg_data_i[13:0]) > 32'(MAX_PANO_DIM)) begin
      pano_sat = 14'(MAX_PANO_DIM);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_w_q <= 13'd640;
      proj_h_q <= 13'd480;
      pano_w_q <= 14'd4096;
      pano_h_q <= 14'd2048;
      step_y_q <= 32'd16777216;
      step_z_q <= 32'd16777216;
      yaw_q    <= '0;
      pitch_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_q) begin
      unique case (cfg_index_i)
        CFG_PROJ_WIDTH:  proj_w_q <= view_sat;
        CFG_PROJ_HEIGHT: proj_h_q <= view_sat;
        CFG_PANO_WIDTH:  pano_w_q <= pano_sat;
        CFG_PANO_HEIGHT: pano_h_q <= pano_sat;
        CFG_RAY_STEP_Y:  step_y_q <= cfg_data_i;
        CFG_RAY_STEP_Z:  step_z_q <= cfg_data_i;
        CFG_YAW_ANGLE:   yaw_q    <= $signed(cfg_data_i[15:0]);
        CFG_PITCH_ANGLE: pitch_q  <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sine/cosine chains
  // chain 0 follows pitch, chain 1 follows yaw
  logic signed [CW-1:0] sc_x [2][NITER+1];
  logic signed [CW-1:0] sc_y [2][NITER+1];
  logic signed [CW-1:0] sc_z [2][NITER+1];
  logic                 sc_f [2][NITER+1];
  logic signed [31:0]   sc_c_q [2];
  logic signed [31:0]   sc_s_q [2];

  for (genvar g = 0; g < 2; g++) begin : g_sc
    logic [15:0] ang, fold;
    logic        flip;
    assign ang  = (g == 0) ? pitch_q : yaw_q;
    assign flip = 16'(ang + 16'h4000) >> 15 != 16'd0;
    // fold angles beyond a quarter turn by a half turn
    assign fold = flip ? (ang ^ 16'h8000) : ang;
    assign sc_x[g][0] = $signed(CW'(INV_GAIN_Q30));
    assign sc_y[g][0] = '0;
    assign sc_z[g][0] = CW'($signed({fold, 16'h0000}));
    assign sc_f[g][0] = flip;

    for (genvar k = 0; k < NITER; k++) begin : g_cell
      pvrc_rot_cell #(.IDX(k), .PW(1)) u_cell (
        .clk_i (clk_i),
        .x_i   (sc_x[g][k]),
        .y_i   (sc_y[g][k]),
        .z_i   (sc_z[g][k]),
        .pay_i (sc_f[g][k]),
        .x_o   (sc_x[g][k+1]),
        .y_o   (sc_y[g][k+1]),
        .z_o   (sc_z[g][k+1]),
        .pay_o (sc_f[g][k+1])
      );
    end

    always_ff @(posedge clk_i) begin
      sc_c_q[g] <= sc_f[g][NITER] ? 32'(-sc_x[g][NITER]) : 32'(sc_x[g][NITER]);
      sc_s_q[g] <= sc_f[g][NITER] ? 32'(-sc_y[g][NITER]) : 32'(sc_y[g][NITER]);
    end
  end

  // ---------------------------------------------------------------- input delay line
  // line up pixels with the angle chains after a configuration write
  logic [11:0] dl_row_q [DLY];
  logic [11:0] dl_col_q [DLY];
  logic        dl_vld_q [DLY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DLY; i++) dl_vld_q[i] <= 1'b0;
    end else begin
      dl_vld_q[0] <= accept;
      for (int i = 1; i < DLY; i++) dl_vld_q[i] <= dl_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dl_row_q[0] <= pixel_row_i;
    dl_col_q[0] <= pixel_col_i;
    for (int i = 1; i < DLY; i++) begin
      dl_row_q[i] <= dl_row_q[i-1];
      dl_col_q[i] <= dl_col_q[i-1];
    end
  end

  // ---------------------------------------------------------------- ray front end
  logic signed [14:0] a_dy, a_dz;
  logic signed [32:0] a_sty, a_stz;
  logic signed [47:0] a_vy_d, a_vz_d, a_vy_q, a_vz_q;
  logic [47:0]        b_my_q, b_mz_q, b_or_q, c_my_q, c_mz_q;
  logic               b_sy_q, b_sz_q, c_sy_q, c_sz_q;
  logic [5:0]         c_top;
  logic [4:0]         c_sh_q;
  logic [47:0]        d_ty, d_tz;
  logic signed [30:0] d_vx_q, d_vy_q, d_vz_q;

  assign a_dy  = $signed({2'b00, dl_col_q[DLY-1], 1'b1}) - $signed({2'b00, proj_w_q});
  assign a_dz  = $signed({2'b00, proj_h_q}) - $signed({2'b00, dl_row_q[DLY-1], 1'b1});
  assign a_sty = $signed({1'b0, step_y_q});
  assign a_stz = $signed({1'b0, step_z_q});
  assign a_vy_d = a_dy * a_sty;
  assign a_vz_d = a_dz * a_stz;

  // bit length of the widest component sets the normalizing shift
  always_comb begin
    c_top = '0;
    for (int i = 0; i < 48; i++) begin
      if (b_or_q[i]) c_top = 6'(i);
    end
  end

  assign d_ty = c_my_q >> c_sh_q;
  assign d_tz = c_mz_q >> c_sh_q;

  always_ff @(posedge clk_i) begin
    a_vy_q <= a_vy_d;
    a_vz_q <= a_vz_d;
    b_my_q <= a_vy_q[47] ? 48'(-a_vy_q) : 48'(a_vy_q);
    b_mz_q <= a_vz_q[47] ? 48'(-a_vz_q) : 48'(a_vz_q);
    b_sy_q <= a_vy_q[47];
    b_sz_q <= a_vz_q[47];
    b_or_q <= VX_RAY | (a_vy_q[47] ? 48'(-a_vy_q) : 48'(a_vy_q))
                     | (a_vz_q[47] ? 48'(-a_vz_q) : 48'(a_vz_q));
    c_sh_q <= 5'(c_top - 6'd29);
    c_my_q <= b_my_q;
    c_mz_q <= b_mz_q;
    c_sy_q <= b_sy_q;
    c_sz_q <= b_sz_q;
    d_vx_q <= $signed(31'(VX_RAY >> c_sh_q));
    d_vy_q <= c_sy_q ? -$signed(31'(d_ty)) : $signed(31'(d_ty));
    d_vz_q <= c_sz_q ? -$signed(31'(d_tz)) : $signed(31'(d_tz));
  end

  // ---------------------------------------------------------------- rotation
  logic signed [62:0] r1_cx_q, r1_sz_q, r1_sx_q, r1_cz_q;
  logic signed [30:0] r1_vy_q, r2_vy_q;
  logic signed [63:0] r2_xs, r2_zs;
  logic signed [32:0] r2_x1_q, r2_z1_q, r3_z1_q, r4_z1_q;
  logic signed [64:0] r3_cx_q, r3_sy_q, r3_sx_q, r3_cy_q;
  logic signed [65:0] r4_xs, r4_ys;
  logic signed [CW-1:0] r4_x2_q, r4_y2_q;

  assign r2_xs = 64'(r1_cx_q) - 64'(r1_sz_q);
  assign r2_zs = 64'(r1_sx_q) + 64'(r1_cz_q);
  assign r4_xs = 66'(r3_cx_q) - 66'(r3_sy_q);
  assign r4_ys = 66'(r3_sx_q) + 66'(r3_cy_q);

  always_ff @(posedge clk_i) begin
    r1_cx_q <= sc_c_q[0] * d_vx_q;
    r1_sz_q <= sc_s_q[0] * d_vz_q;
    r1_sx_q <= sc_s_q[0] * d_vx_q;
    r1_cz_q <= sc_c_q[0] * d_vz_q;
    r1_vy_q <= d_vy_q;
    r2_x1_q <= 33'(r2_xs >>> 30);
    r2_z1_q <= 33'(r2_zs >>> 30);
    r2_vy_q <= r1_vy_q;
    r3_cx_q <= sc_c_q[1] * r2_x1_q;
    r3_sy_q <= sc_s_q[1] * r2_vy_q;
    r3_sx_q <= sc_s_q[1] * r2_x1_q;
    r3_cy_q <= sc_c_q[1] * r2_vy_q;
    r3_z1_q <= r2_z1_q;
    r4_x2_q <= CW'(r4_xs >>> 30);
    r4_y2_q <= CW'(r4_ys >>> 30);
    r4_z1_q <= r3_z1_q;
  end

  // ---------------------------------------------------------------- longitude chain
  // payload: zero flag, base +pi, base -pi, z1
  localparam int unsigned LPW = 36;
  logic signed [CW-1:0] lo_x [NITER+1];
  logic signed [CW-1:0] lo_y [NITER+1];
  logic signed [CW-1:0] lo_z [NITER+1];
  logic [LPW-1:0]       lo_p [NITER+1];
  logic                 lo_v [NITER+1];
  logic signed [CW-1:0] f_x_q, f_y_q;
  logic [LPW-1:0]       f_p_q;

  always_ff @(posedge clk_i) begin
    f_x_q <= r4_x2_q[CW-1] ? -r4_x2_q : r4_x2_q;
    f_y_q <= r4_x2_q[CW-1] ? -r4_y2_q : r4_y2_q;
    f_p_q <= {(r4_x2_q == '0) && (r4_y2_q == '0),
              r4_x2_q[CW-1] && !r4_y2_q[CW-1],
              r4_x2_q[CW-1] && r4_y2_q[CW-1],
              r4_z1_q};
  end

  assign lo_x[0] = f_x_q;
  assign lo_y[0] = f_y_q;
  assign lo_z[0] = '0;
  assign lo_p[0] = f_p_q;

  for (genvar k = 0; k < NITER; k++) begin : g_lon
    pvrc_vec_cell #(.IDX(k), .PW(LPW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lo_v[k]),
      .x_i     (lo_x[k]),
      .y_i     (lo_y[k]),
      .z_i     (lo_z[k]),
      .pay_i   (lo_p[k]),
      .valid_o (lo_v[k+1]),
      .x_o     (lo_x[k+1]),
      .y_o     (lo_y[k+1]),
      .z_o     (lo_z[k+1]),
      .pay_o   (lo_p[k+1])
    );
  end

  // ---------------------------------------------------------------- wrap and magnitude
  logic                 g_zero, g_bp, g_bn;
  logic signed [CW-1:0] g_raw, g_wrap;
  logic [CW-1:0]        g_mag;
  logic [65:0]          g_prod;
  logic signed [32:0]   g_lon_q;
  logic signed [CW-1:0] g_hyp_q;
  logic signed [32:0]   g_z1_q;

  assign g_zero = lo_p[NITER][35];
  assign g_bp   = lo_p[NITER][34];
  assign g_bn   = lo_p[NITER][33];

  always_comb begin
    g_raw = lo_z[NITER];
    if (g_bp) g_raw = lo_z[NITER] + HALF;
    if (g_bn) g_raw = lo_z[NITER] - HALF;
    g_wrap = g_raw;
    if (g_raw > HALF) g_wrap = g_raw - TURN;
    if (g_raw <= -HALF) g_wrap = g_raw + TURN;
    if (g_zero) g_wrap = '0;
    g_mag  = g_zero ? '0 : $unsigned(lo_x[NITER]);
    g_prod = 66'(g_mag) * 66'(INV_GAIN_Q30);
  end

  always_ff @(posedge clk_i) begin
    g_lon_q <= 33'(g_wrap);
    g_hyp_q <= $signed(CW'(g_prod >> 30));
    g_z1_q  <= $signed(lo_p[NITER][32:0]);
  end

  // ---------------------------------------------------------------- latitude chain
  // payload: zero flag, longitude
  localparam int unsigned TPW = 34;
  logic signed [CW-1:0] la_x [NITER+1];
  logic signed [CW-1:0] la_y [NITER+1];
  logic signed [CW-1:0] la_z [NITER+1];
  logic [TPW-1:0]       la_p [NITER+1];
  logic                 la_v [NITER+1];

  assign la_x[0] = g_hyp_q;
  assign la_y[0] = CW'(g_z1_q);
  assign la_z[0] = '0;
  assign la_p[0] = {(g_hyp_q == '0) && (g_z1_q == '0), g_lon_q};

  for (genvar k = 0; k < NITER; k++) begin : g_lat
    pvrc_vec_cell #(.IDX(k), .PW(TPW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (la_v[k]),
      .x_i     (la_x[k]),
      .y_i     (la_y[k]),
      .z_i     (la_z[k]),
      .pay_i   (la_p[k]),
      .valid_o (la_v[k+1]),
      .x_o     (la_x[k+1]),
      .y_o     (la_y[k+1]),
      .z_o     (la_z[k+1]),
      .pay_o   (la_p[k+1])
    );
  end

  // ---------------------------------------------------------------- scale to panorama
  logic signed [CW-1:0] h_lat;
  logic signed [32:0]   h_lon;
  logic [32:0]          h1_ux_q;
  logic [31:0]          h1_uy_q;
  logic [13:0]          pw1, ph1;
  logic [46:0]          h2_px_q;
  logic [45:0]          h2_py_q;
  logic [47:0]          h3_rx, h3_ry;

  assign h_lon = $signed(la_p[NITER][32:0]);

  always_comb begin
    h_lat = la_p[NITER][33] ? '0 : la_z[NITER];
    if (h_lat > QTR) h_lat = QTR;
    if (h_lat < -QTR) h_lat = -QTR;
  end

  assign pw1   = (pano_w_q == '0) ? '0 : pano_w_q - 14'd1;
  assign ph1   = (pano_h_q == '0) ? '0 : pano_h_q - 14'd1;
  assign h3_rx = (48'(h2_px_q) + 48'h80_0000) >> 24;
  assign h3_ry = (48'(h2_py_q) + 48'h40_0000) >> 23;

  logic [20:0] map_x_q, map_y_q;

  always_ff @(posedge clk_i) begin
    h1_ux_q <= 33'(34'(h_lon) + 34'h0_8000_0000);
    h1_uy_q <= 32'h4000_0000 - 32'(h_lat);
    h2_px_q <= 47'(pw1) * 47'(h1_ux_q);
    h2_py_q <= 46'(ph1) * 46'(h1_uy_q);
    map_x_q <= (h3_rx > 48'(OUT_MAX)) ? OUT_MAX : 21'(h3_rx);
    map_y_q <= (h3_ry > 48'(OUT_MAX)) ? OUT_MAX : 21'(h3_ry);
  end

  // ---------------------------------------------------------------- valid pipeline
  logic a_v_q, b_v_q, c_v_q, d_v_q, r1_v_q, r2_v_q, r3_v_q, r4_v_q, f_v_q, g_v_q;
  logic h1_v_q, h2_v_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      d_v_q  <= 1'b0;
      r1_v_q <= 1'b0;
      r2_v_q <= 1'b0;
      r3_v_q <= 1'b0;
      r4_v_q <= 1'b0;
      f_v_q  <= 1'b0;
      g_v_q  <= 1'b0;
      h1_v_q <= 1'b0;
      h2_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      a_v_q  <= dl_vld_q[DLY-1];
      b_v_q  <= a_v_q;
      c_v_q  <= b_v_q;
      d_v_q  <= c_v_q;
      r1_v_q <= d_v_q;
      r2_v_q <= r1_v_q;
      r3_v_q <= r2_v_q;
      r4_v_q <= r3_v_q;
      f_v_q  <= r4_v_q;
      g_v_q  <= lo_v[NITER];
      h1_v_q <= la_v[NITER];
      h2_v_q <= h1_v_q;
      done_q <= h2_v_q;
    end
  end

  assign lo_v[0] = f_v_q;
  assign la_v[0] = g_v_q;

  assign done_o  = done_q;
  assign map_x_o = map_x_q;
  assign map_y_o = map_y_q;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LATENCY) done_o)
    else $error("accepted pixel gave no result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without an accepted pixel");

  a_x_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(map_x_o) <= (32'(pw1) << 8)))
    else $error("map_x beyond panorama width");

  a_y_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(map_y_o) <= (32'(ph1) << 8)))
    else $error("map_y beyond panorama height");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of panorama_view_remap_coordinates_core.
// Drives pixel words and register writes, and checks every map coordinate against a
// built-in fixed-point model or a typed known answer. Depends on rtl/pvrc_pkg.sv.
`timescale 1ns / 100ps

module tb_top;
  import pvrc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [11:0] pixel_row_i = '0;
  logic [11:0] pixel_col_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        done_o;
  logic [20:0] map_x_o;
  logic [20:0] map_y_o;

  panorama_view_remap_coordinates_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .pixel_row_i(pixel_row_i), .pixel_col_i(pixel_col_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .done_o(done_o), .map_x_o(map_x_o), .map_y_o(map_y_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  localparam int NSTEPS = 16;
  localparam longint INV_GAIN = 64'd652032874;
  localparam longint PI_BA = 64'sd2147483648;
  localparam longint HALF_PI_BA = 64'sd1073741824;
  localparam int WATCHDOG_LIMIT = 4000;

  longint atan_ba [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // mirrored register file
  logic [12:0] view_w, view_h;
  logic [13:0] pano_w, pano_h;
  logic [31:0] step_y, step_z;
  logic [15:0] yaw, pitch;

  typedef struct packed {
    logic [20:0] x;
    logic [20:0] y;
  } map_coord_t;

  map_coord_t coord_q[$];
  int errors = 0;
  int pix_taken = 0;
  int cfg_taken = 0;
  int quiet_cycles = 0;

  function automatic longint sym_shr(input longint v, input int s);
    return (v < 0) ? -((-v) >> s) : (v >> s);
  endfunction

  function automatic void rot_sincos(input logic [15:0] ang, output longint c,
                                     output longint s);
    logic [31:0] a, t;
    logic flip;
    longint z, x, y, nx;
    a = {ang, 16'h0};
    t = a + 32'h4000_0000;
    flip = t[31];
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = INV_GAIN;
    y = 0;
    for (int i = 0; i < NSTEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_ba[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_ba[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void vec_angle(input longint xi, input longint yi, output longint ang,
                                    output longint mag);
    longint x, y, z, nx;
    x = xi; y = yi; z = 0;
    if (x == 0 && y == 0) begin
      ang = 0; mag = 0;
      return;
    end
    for (int i = 0; i < NSTEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_ba[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_ba[i];
      end
      x = nx;
    end
    ang = z;
    mag = x;
  endfunction

  function automatic map_coord_t remap_pixel(input logic [11:0] row, input logic [11:0] col);
    longint vx, vy, vz, cp, sp, cy, sy, x1, z1, x2, y2, base, lon, lat, mag, hyp;
    longint lim, pw1, ph1, mx, my;
    map_coord_t r;
    lim = 64'sd1 << 30;
    vx = 64'sd240 << 24;
    vy = (2 * longint'(col) - longint'(view_w) + 1) * longint'(step_y);
    vz = -(2 * longint'(row) - longint'(view_h) + 1) * longint'(step_z);
    while (vx >= lim || vy >= lim || vy <= -lim || vz >= lim || vz <= -lim) begin
      vx = sym_shr(vx, 1); vy = sym_shr(vy, 1); vz = sym_shr(vz, 1);
    end
    rot_sincos(pitch, cp, sp);
    rot_sincos(yaw, cy, sy);
    x1 = (cp * vx - sp * vz) >>> 30;
    z1 = (sp * vx + cp * vz) >>> 30;
    x2 = (cy * x1 - sy * vy) >>> 30;
    y2 = (sy * x1 + cy * vy) >>> 30;
    base = 0;
    // fold the left half plane, then add back pi with the sign of y
    if (x2 < 0) begin
      base = (y2 >= 0) ? PI_BA : -PI_BA;
      x2 = -x2; y2 = -y2;
    end
    vec_angle(x2, y2, lon, mag);
    lon = lon + base;
    if (lon > PI_BA) lon = lon - 2 * PI_BA;
    if (lon <= -PI_BA) lon = lon + 2 * PI_BA;
    hyp = (mag * INV_GAIN) >> 30;
    vec_angle(hyp, z1, lat, mag);
    if (lat > HALF_PI_BA) lat = HALF_PI_BA;
    if (lat < -HALF_PI_BA) lat = -HALF_PI_BA;
    pw1 = (pano_w != 0) ? longint'(pano_w) - 1 : 0;
    ph1 = (pano_h != 0) ? longint'(pano_h) - 1 : 0;
    mx = (pw1 * (PI_BA + lon) + (64'sd1 << 23)) >> 24;
    my = (ph1 * (HALF_PI_BA - lat) + (64'sd1 << 22)) >> 23;
    r.x = (mx > 2097151) ? OUT_MAX : mx[20:0];
    r.y = (my > 2097151) ? OUT_MAX : my[20:0];
    return r;
  endfunction

  function automatic void apply_reg(input cfg_idx_e idx, input logic [31:0] d);
    case (idx)
      CFG_PROJ_WIDTH:  view_w = (d[12:0] > 13'd4096) ? 13'd4096 : d[12:0];
      CFG_PROJ_HEIGHT: view_h = (d[12:0] > 13'd4096) ? 13'd4096 : d[12:0];
      CFG_PANO_WIDTH:  pano_w = (d[13:0] > 14'd8192) ? 14'd8192 : d[13:0];
      CFG_PANO_HEIGHT: pano_h = (d[13:0] > 14'd8192) ? 14'd8192 : d[13:0];
      CFG_RAY_STEP_Y:  step_y = d;
      CFG_RAY_STEP_Z:  step_z = d;
      CFG_YAW_ANGLE:   yaw = d[15:0];
      CFG_PITCH_ANGLE: pitch = d[15:0];
      default: ;
    endcase
  endfunction

  initial begin
    view_w = 13'd640; view_h = 13'd480;
    pano_w = 14'd4096; pano_h = 14'd2048;
    step_y = 32'd16777216; step_z = 32'd16777216;
    yaw = '0; pitch = '0;
  end

  // sample accepts and results at the rising edge
  always @(posedge clk_i) begin
    automatic logic got = 1'b0;
    automatic map_coord_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
        cfg_taken++;
        got = 1'b1;
      end
      if (start_i && !busy_o) begin
        coord_q.push_back(remap_pixel(pixel_row_i, pixel_col_i));
        pix_taken++;
        got = 1'b1;
      end
      if (done_o) begin
        got = 1'b1;
        if (coord_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d", $time, map_x_o, map_y_o);
          errors++;
        end else begin
          want = coord_q.pop_front();
          if (want.x !== map_x_o) begin
            $display("%0t: map_x expected %0d actual %0d", $time, want.x, map_x_o);
            errors++;
          end
          if (want.y !== map_y_o) begin
            $display("%0t: map_y expected %0d actual %0d", $time, want.y, map_y_o);
            errors++;
          end
        end
      end
      quiet_cycles = got ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[panorama_view_remap_coordinates_core] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] d);
    int n;
    n = cfg_taken;
    @(negedge clk_i);
    cfg_valid_i = 1'b1; cfg_index_i = idx; cfg_data_i = d;
    do @(negedge clk_i); while (cfg_taken == n);
    cfg_valid_i = 1'b0;
    cfg_data_i = $urandom;
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain();
    while (coord_q.size() != 0) @(negedge clk_i);
    repeat (70) @(negedge clk_i);
  endtask

  // hold start until the word is taken; idle_pct sets the gap chance
  task automatic send_pixel(input logic [11:0] row, input logic [11:0] col, input int idle_pct);
    int n;
    if ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      pixel_row_i = $urandom; pixel_col_i = $urandom;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    n = pix_taken;
    start_i = 1'b1; pixel_row_i = row; pixel_col_i = col;
    do @(negedge clk_i); while (pix_taken == n);
  endtask

  task automatic set_view(input logic [31:0] w, input logic [31:0] h, input logic [31:0] pw,
                          input logic [31:0] ph, input logic [31:0] sy, input logic [31:0] sz,
                          input logic [31:0] yw, input logic [31:0] pt);
    write_reg(CFG_PROJ_WIDTH, w);
    write_reg(CFG_PROJ_HEIGHT, h);
    write_reg(CFG_PANO_WIDTH, pw);
    write_reg(CFG_PANO_HEIGHT, ph);
    write_reg(CFG_RAY_STEP_Y, sy);
    write_reg(CFG_RAY_STEP_Z, sz);
    write_reg(CFG_YAW_ANGLE, yw);
    write_reg(CFG_PITCH_ANGLE, pt);
  endtask

  typedef struct {
    logic [11:0] row;
    logic [11:0] col;
    bit          typed;
    logic [20:0] ex;
    logic [20:0] ey;
  } pixel_vec_t;

  // rows 0..7 at reset setup, 8..15 looking straight up, 16.. with zero panorama size
  pixel_vec_t vecs [24] = '{
    '{12'd0, 12'd0, 0, 0, 0}, '{12'd4095, 12'd4095, 0, 0, 0},
    '{12'd0, 12'd4095, 0, 0, 0}, '{12'd4095, 12'd0, 0, 0, 0},
    '{12'd239, 12'd319, 0, 0, 0}, '{12'd240, 12'd320, 0, 0, 0},
    '{12'd239, 12'd320, 0, 0, 0}, '{12'd2730, 12'd1365, 0, 0, 0},
    '{12'd239, 12'd319, 0, 0, 0}, '{12'd240, 12'd320, 0, 0, 0},
    '{12'd240, 12'd319, 0, 0, 0}, '{12'd239, 12'd320, 0, 0, 0},
    '{12'd0, 12'd320, 0, 0, 0}, '{12'd479, 12'd320, 0, 0, 0},
    '{12'd240, 12'd0, 0, 0, 0}, '{12'd240, 12'd639, 0, 0, 0},
    '{12'd0, 12'd0, 1, 0, 0}, '{12'd4095, 12'd4095, 1, 0, 0},
    '{12'd1365, 12'd2730, 1, 0, 0}, '{12'd240, 12'd320, 1, 0, 0},
    '{12'd4095, 12'd0, 1, 0, 0}, '{12'd0, 12'd4095, 1, 0, 0},
    '{12'd100, 12'd200, 1, 0, 0}, '{12'd2048, 12'd2048, 1, 0, 0}
  };

  initial begin
    int idle_pct;
    logic [11:0] r, c;
    logic [31:0] w, h;
    pixel_vec_t v;
    map_coord_t want;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 24; i++) begin
      v = vecs[i];
      if (i == 8 || i == 16) begin
        start_i = 1'b0;
        drain();
        if (i == 8) write_reg(CFG_PITCH_ANGLE, 32'd16384);
        else begin
          write_reg(CFG_PANO_WIDTH, 32'd0);
          write_reg(CFG_PANO_HEIGHT, 32'd0);
        end
      end
      send_pixel(v.row, v.col, 20);
      if (v.typed) begin
        // overwrite the model's guess with the known answer
        want.x = v.ex; want.y = v.ey;
        coord_q[coord_q.size() - 1] = want;
      end
    end

    for (int seg = 0; seg < 6; seg++) begin
      start_i = 1'b0;
      drain();
      case (seg)
        0: set_view(32'd8191, 32'd4096, 32'd16383, 32'd8192, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h8000, 32'd16384);
        1: set_view(32'd2, 32'd2, 32'd2, 32'd2, 32'd0, 32'd0, 32'h7FFF, 32'hC000);
        default: set_view($urandom_range(4096, 2), $urandom_range(4096, 2),
                          $urandom_range(8192, 2), $urandom_range(8192, 2),
                          ($urandom_range(3) == 0) ? $urandom : $urandom_range(33554432),
                          ($urandom_range(3) == 0) ? $urandom : $urandom_range(33554432),
                          $urandom, ($urandom_range(3) == 0) ? $urandom
                                                             : $urandom_range(32768) - 16384);
      endcase
      idle_pct = (seg < 2) ? 30 : (seg < 4) ? 74 : 0;
      w = view_w; h = view_h;
      for (int k = 0; k < 275; k++) begin
        if ($urandom_range(9) == 0) begin
          r = $urandom; c = $urandom;
        end else begin
          r = $urandom_range(h - 1); c = $urandom_range(w - 1);
        end
        send_pixel(r, c, idle_pct);
      end
    end

    start_i = 1'b0;
    while (coord_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0) $display("[panorama_view_remap_coordinates_core] OK");
    else $display("[panorama_view_remap_coordinates_core] ERROR");
    $finish;
  end

endmodule
